// File: src/rvx_pkg.sv
package rvx_pkg;

  // Major opcodes.
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
  localparam logic [31:0] UPPER_MASK = 32'hffff_f000;

  // Environment call numbers held in a7.
  localparam logic [31:0] CALL_GETC  = 32'd1;
  localparam logic [31:0] CALL_PUTC  = 32'd2;
  localparam logic [31:0] CALL_EXIT  = 32'd3;
  localparam logic [31:0] CALL_EXIT2 = 32'd93;

  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // Stop causes.
  localparam logic [1:0] CAUSE_RUN     = 2'd0;
  localparam logic [1:0] CAUSE_EXIT    = 2'd1;
  localparam logic [1:0] CAUSE_BADCALL = 2'd2;
  localparam logic [1:0] CAUSE_ILLEGAL = 2'd3;

  localparam logic ACT_LOADW = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_AMOD, S_AWAIT, S_WRITE, S_RD_ADDR, S_RD_DATA,
    S_REGRD, S_EXEC, S_MUL, S_DIVGO, S_DIVW, S_FIN
  } state_t;

  typedef enum logic [1:0] {PH_LOADW, PH_FETCH, PH_LOAD, PH_STORE} phase_t;

  typedef enum logic [2:0] {EX_DONE, EX_MUL, EX_DIV, EX_LOAD, EX_STORE} ex_kind_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// File: src/rvx_div.sv
module rvx_div (
  input  logic            clk,
  input  logic            rst_n,
  input  rvx_pkg::div_req_t req,
  output rvx_pkg::div_rsp_t rsp
);
  import rvx_pkg::*;

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic [32:0] shifted, diff;
  logic        ge;

  // One restoring step per cycle, quotient bits shift in from the right.
  always_comb begin
    shifted = {rem_r, quo_r[31]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = ~diff[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: src/rv32im_instruction_executor.sv
// RV32IM multicycle core with a private byte memory and register file.
// Input channel (in_valid/in_stall): one beat is either a program word write
// (in_action 0, word at byte 4*index, little-endian) or one instruction to
// execute (in_action 1). Every input beat yields exactly one output beat with
// the core status, the program counter after the beat, console traffic and
// the saturating retired count.
// Memory is read and written one byte per port access. A program word write
// wraps its address and writes four bytes; an execute beat wraps the PC,
// fetches four bytes, reads registers and executes, then an n-byte load or
// store wraps its address and moves n bytes, a multiply forms its product and
// a divide or remainder runs in the shared divider; each beat then posts its
// result. Wrapping truncates when MEM_BYTES is a power of two, else uses the
// divider remainder. A stopped core's execute beat goes straight to posting.
// The result sits in an output register; a new input beat is taken while it
// waits, and a later result waits in the final state until out_stall falls.
// Reset clears the register file (per-entry valid bits), status, count and
// program counter; memory contents stay undefined until written. The start
// register at APB address 0 sets the start address and the program counter.
module rv32im_instruction_executor #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [13:0] in_load_word_index,
  input  logic [31:0] in_load_word,
  input  logic signed [8:0] in_console_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_halted,
  output logic [1:0]  out_halt_cause,
  output logic [31:0] out_next_pc,
  output logic        out_char_out_valid,
  output logic [7:0]  out_char_out,
  output logic        out_console_consumed,
  output logic [31:0] out_retired_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rvx_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);
  localparam bit POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [31:0] start_pc_r, pc_r, retired_r;
  logic        halted_r;
  logic [1:0]  cause_r;

  logic [31:0] a_r, wdat_r, buf_r, inst_r, res_r, next_r;
  logic [AW-1:0] maddr_r;
  logic [1:0]  cnt_r, nb_r;
  logic [8:0]  con_r;
  logic [2:0]  f3_r;
  logic        wb_r, cvalid_r, consumed_r, stop_req_r;
  logic [4:0]  rd_r;
  logic [7:0]  cchar_r;
  logic [1:0]  stop_code_r;
  logic [65:0] prod_r;
  logic        neg_q_r, neg_r_r, bzero_r;
  logic [31:0] dva_r;

  logic        out_valid_r, out_halted_r, out_cvalid_r, out_consumed_r;
  logic [1:0]  out_cause_r;
  logic [31:0] out_pc_r, out_retired_r;
  logic [7:0]  out_char_r;

  logic        in_acc, out_free, commit, cfg_wr, mem_we, last_byte, div_addr;
  logic [31:0] ld_word;
  div_req_t    dreq;
  div_rsp_t    drsp;

  // Byte memory, one write and one registered read port.
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[maddr_r] <= wdat_r[{cnt_r, 3'b000} +: 8];
    end
    mem_q_r <= mem[maddr_r];
  end

  // Register file with two registered read ports; x0 never becomes valid.
  logic [31:0] rf [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rfa_q_r, rfb_q_r;
  logic        rfa_v_r, rfb_v_r, rf_we, is_ecall_word;
  logic [4:0]  rfa_addr, rfb_addr;
  logic [31:0] rs1, rs2;

  assign is_ecall_word = (inst_r == ECALL_WORD);
  assign rfa_addr = is_ecall_word ? REG_A7 : inst_r[19:15];
  assign rfb_addr = is_ecall_word ? REG_A0 : inst_r[24:20];
  assign rf_we    = commit && wb_r && (rd_r != 5'd0);

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rd_r] <= res_r;
    end
    rfa_q_r <= rf[rfa_addr];
    rfb_q_r <= rf[rfb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rfa_v_r  <= 1'b0;
      rfb_v_r  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rd_r] <= 1'b1;
      end
      rfa_v_r <= rf_vld_r[rfa_addr];
      rfb_v_r <= rf_vld_r[rfb_addr];
    end
  end

  assign rs1 = rfa_v_r ? rfa_q_r : '0;
  assign rs2 = rfb_v_r ? rfb_q_r : '0;

  // Shared divider: address wrapping and DIV/REM.
  rvx_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign div_addr      = (state_r == S_AMOD);
  assign dreq.start    = (div_addr && !POW2) || (state_r == S_DIVGO);
  assign dreq.dividend = div_addr ? a_r : dva_r;
  assign dreq.divisor  = div_addr ? 32'(MEM_BYTES) :
                         ((f3_r[0] || !rs2[31]) ? rs2 : 32'd0 - rs2);

  // Handshake and status.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_FIN) && out_free;
  assign mem_we   = (state_r == S_WRITE);
  assign last_byte = (cnt_r == nb_r);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr == 3'd0) ? start_pc_r : '0;

  // Word assembled with the byte that arrives this cycle.
  always_comb begin
    ld_word = buf_r;
    ld_word[{cnt_r, 3'b000} +: 8] = mem_q_r;
  end

  // Instruction execution.
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immj, pc4, ex_res, ex_next, ex_ea;
  logic        ex_wb, ex_bad, ex_cvalid, ex_consumed, ex_stop, taken;
  logic [1:0]  ex_code, ex_nb;
  logic [4:0]  ex_rd, sh;
  ex_kind_t    ex_kind;

  assign opc  = inst_r[6:0];
  assign f3   = inst_r[14:12];
  assign f7   = inst_r[31:25];
  assign immi = {{20{inst_r[31]}}, inst_r[31:20]};
  assign imms = {{20{inst_r[31]}}, inst_r[31:25], inst_r[11:7]};
  assign immb = {{19{inst_r[31]}}, inst_r[31], inst_r[7], inst_r[30:25], inst_r[11:8], 1'b0};
  assign immj = {{11{inst_r[31]}}, inst_r[31], inst_r[19:12], inst_r[20], inst_r[30:21],
                 1'b0};
  assign pc4  = pc_r + 32'd4;

  always_comb begin
    ex_res      = '0;
    ex_next     = pc4;
    ex_wb       = 1'b0;
    ex_bad      = 1'b0;
    ex_cvalid   = 1'b0;
    ex_consumed = 1'b0;
    ex_stop     = 1'b0;
    ex_code     = CAUSE_RUN;
    ex_rd       = inst_r[11:7];
    ex_kind     = EX_DONE;
    ex_ea       = rs1 + immi;
    ex_nb       = (f3[1:0] == 2'd0) ? 2'd0 : ((f3[1:0] == 2'd1) ? 2'd1 : 2'd3);
    taken       = 1'b0;
    sh          = inst_r[24:20];
    unique case (opc)
      OP_LUI: begin
        ex_res = inst_r & UPPER_MASK;
        ex_wb  = 1'b1;
      end
      OP_AUIPC: begin
        ex_res = pc_r + (inst_r & UPPER_MASK);
        ex_wb  = 1'b1;
      end
      OP_JAL: begin
        ex_res  = pc4;
        ex_wb   = 1'b1;
        ex_next = pc_r + immj;
      end
      OP_JALR: begin
        ex_res  = pc4;
        ex_wb   = 1'b1;
        ex_next = (rs1 + immi) & ~32'd1;
      end
      OP_BRANCH: begin
        unique case (f3)
          3'd0: taken = (rs1 == rs2);
          3'd1: taken = (rs1 != rs2);
          3'd4: taken = ($signed(rs1) < $signed(rs2));
          3'd5: taken = !($signed(rs1) < $signed(rs2));
          3'd6: taken = (rs1 < rs2);
          3'd7: taken = (rs1 >= rs2);
          default: ex_bad = 1'b1;
        endcase
        if (taken) begin
          ex_next = pc_r + immb;
        end
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
          ex_bad = 1'b1;
        end else begin
          ex_kind = EX_LOAD;
          ex_wb   = 1'b1;
        end
      end
      OP_STORE: begin
        ex_ea = rs1 + imms;
        if (f3 > 3'd2) begin
          ex_bad = 1'b1;
        end else begin
          ex_kind = EX_STORE;
        end
      end
      OP_IMM: begin
        ex_wb = 1'b1;
        unique case (f3)
          3'd0: ex_res = rs1 + immi;
          3'd2: ex_res = {31'd0, $signed(rs1) < $signed(immi)};
          3'd3: ex_res = {31'd0, rs1 < immi};
          3'd4: ex_res = rs1 ^ immi;
          3'd6: ex_res = rs1 | immi;
          3'd7: ex_res = rs1 & immi;
          3'd1: begin
            if (f7 == F7_BASE) ex_res = rs1 << sh;
            else ex_bad = 1'b1;
          end
          default: begin
            if (f7 == F7_BASE) ex_res = rs1 >> sh;
            else if (f7 == F7_ALT) ex_res = 32'($signed(rs1) >>> sh);
            else ex_bad = 1'b1;
          end
        endcase
      end
      OP_REG: begin
        ex_wb = 1'b1;
        sh    = rs2[4:0];
        if (f7 == F7_MULDIV) begin
          ex_kind = f3[2] ? EX_DIV : EX_MUL;
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) ex_res = rs1 - rs2;
          else if (f3 == 3'd5) ex_res = 32'($signed(rs1) >>> sh);
          else ex_bad = 1'b1;
        end else if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0: ex_res = rs1 + rs2;
            3'd1: ex_res = rs1 << sh;
            3'd2: ex_res = {31'd0, $signed(rs1) < $signed(rs2)};
            3'd3: ex_res = {31'd0, rs1 < rs2};
            3'd4: ex_res = rs1 ^ rs2;
            3'd5: ex_res = rs1 >> sh;
            3'd6: ex_res = rs1 | rs2;
            default: ex_res = rs1 & rs2;
          endcase
        end else begin
          ex_bad = 1'b1;
        end
      end
      OP_SYSTEM: begin
        if (!is_ecall_word) begin
          ex_bad = 1'b1;
        end else if (rs1 == CALL_GETC) begin
          ex_res      = {{23{con_r[8]}}, con_r};
          ex_rd       = REG_A0;
          ex_wb       = 1'b1;
          ex_consumed = 1'b1;
        end else if (rs1 == CALL_PUTC) begin
          ex_cvalid = 1'b1;
        end else if (rs1 == CALL_EXIT || rs1 == CALL_EXIT2) begin
          ex_stop = 1'b1;
          ex_code = CAUSE_EXIT;
        end else begin
          ex_stop = 1'b1;
          ex_code = CAUSE_BADCALL;
        end
      end
      default: ex_bad = 1'b1;
    endcase
    if (ex_bad) begin
      ex_stop = 1'b1;
      ex_code = CAUSE_ILLEGAL;
      ex_wb   = 1'b0;
      ex_kind = EX_DONE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_action != ACT_LOADW && halted_r) ? S_FIN : S_AMOD;
        end
      end
      S_AMOD: begin
        if (!POW2) state_nxt = S_AWAIT;
        else if (phase_r == PH_LOADW || phase_r == PH_STORE) state_nxt = S_WRITE;
        else state_nxt = S_RD_ADDR;
      end
      S_AWAIT: begin
        if (drsp.done) begin
          if (phase_r == PH_LOADW || phase_r == PH_STORE) state_nxt = S_WRITE;
          else state_nxt = S_RD_ADDR;
        end
      end
      S_WRITE:   if (last_byte) state_nxt = S_FIN;
      S_RD_ADDR: state_nxt = S_RD_DATA;
      S_RD_DATA: begin
        if (!last_byte) state_nxt = S_RD_ADDR;
        else state_nxt = (phase_r == PH_FETCH) ? S_REGRD : S_FIN;
      end
      S_REGRD: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (ex_kind)
          EX_MUL:  state_nxt = S_MUL;
          EX_DIV:  state_nxt = S_DIVGO;
          EX_LOAD, EX_STORE: state_nxt = S_AMOD;
          default: state_nxt = S_FIN;
        endcase
      end
      S_MUL:   state_nxt = S_FIN;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW:  if (drsp.done) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_pc_r  <= '0;
      pc_r        <= '0;
      retired_r   <= '0;
      halted_r    <= 1'b0;
      cause_r     <= CAUSE_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr == 3'd0) begin
        start_pc_r <= pwdata;
        pc_r       <= pwdata;
      end
      if (state_r == S_EXEC && retired_r != 32'hffff_ffff) begin
        retired_r <= retired_r + 32'd1;
      end
      if (commit) begin
        pc_r <= next_r;
        if (stop_req_r) begin
          halted_r <= 1'b1;
          cause_r  <= stop_code_r;
        end
      end
      if (commit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cnt_r      <= '0;
        nb_r       <= 2'd3;
        con_r      <= in_console_in;
        wdat_r     <= in_load_word;
        wb_r       <= 1'b0;
        cvalid_r   <= 1'b0;
        cchar_r    <= '0;
        consumed_r <= 1'b0;
        stop_req_r <= 1'b0;
        stop_code_r <= CAUSE_RUN;
        next_r     <= pc_r;
        if (in_action == ACT_LOADW) begin
          a_r     <= {16'd0, in_load_word_index, 2'b00};
          phase_r <= PH_LOADW;
        end else begin
          a_r     <= pc_r;
          phase_r <= PH_FETCH;
        end
      end
      S_AMOD: begin
        cnt_r   <= '0;
        maddr_r <= a_r[AW-1:0];
      end
      S_AWAIT: begin
        if (drsp.done) maddr_r <= drsp.rem[AW-1:0];
      end
      S_WRITE: begin
        cnt_r   <= cnt_r + 2'd1;
        maddr_r <= (maddr_r == MEM_LAST) ? '0 : maddr_r + 1'b1;
      end
      S_RD_DATA: begin
        buf_r   <= ld_word;
        cnt_r   <= cnt_r + 2'd1;
        maddr_r <= (maddr_r == MEM_LAST) ? '0 : maddr_r + 1'b1;
        if (last_byte) begin
          if (phase_r == PH_FETCH) begin
            inst_r <= ld_word;
          end else begin
            unique case (f3_r)
              3'd0: res_r <= {{24{ld_word[7]}}, ld_word[7:0]};
              3'd1: res_r <= {{16{ld_word[15]}}, ld_word[15:0]};
              3'd4: res_r <= {24'd0, ld_word[7:0]};
              3'd5: res_r <= {16'd0, ld_word[15:0]};
              default: res_r <= ld_word;
            endcase
          end
        end
      end
      S_EXEC: begin
        res_r       <= ex_res;
        next_r      <= ex_next;
        wb_r        <= ex_wb;
        rd_r        <= ex_rd;
        cvalid_r    <= ex_cvalid;
        cchar_r     <= ex_cvalid ? rs2[7:0] : 8'd0;
        consumed_r  <= ex_consumed;
        stop_req_r  <= ex_stop;
        stop_code_r <= ex_code;
        f3_r        <= f3;
        a_r         <= ex_ea;
        nb_r        <= ex_nb;
        wdat_r      <= rs2;
        phase_r     <= (ex_kind == EX_STORE) ? PH_STORE : PH_LOAD;
        prod_r      <= 66'($signed({f3[1:0] != 2'd3 && rs1[31], rs1}) *
                           $signed({f3[1:0] == 2'd1 && rs2[31], rs2}));
        dva_r       <= (f3[0] || !rs1[31]) ? rs1 : 32'd0 - rs1;
        neg_q_r     <= !f3[0] && (rs1[31] ^ rs2[31]);
        neg_r_r     <= !f3[0] && rs1[31];
        bzero_r     <= (rs2 == 32'd0);
      end
      S_MUL: begin
        res_r <= (f3_r[1:0] == 2'd0) ? prod_r[31:0] : prod_r[63:32];
      end
      S_DIVW: begin
        if (drsp.done) begin
          if (!f3_r[1]) begin
            res_r <= bzero_r ? 32'hffff_ffff : (neg_q_r ? 32'd0 - drsp.quo : drsp.quo);
          end else begin
            res_r <= bzero_r ? a_r : (neg_r_r ? 32'd0 - drsp.rem : drsp.rem);
          end
        end
      end
      default: begin
      end
    endcase
    // The divide operand a_r holds rs1 for the zero-divisor remainder case.
    if (state_r == S_DIVGO) a_r <= (dva_r == dva_r) ? (neg_r_r ? 32'd0 - dva_r : dva_r) : a_r;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_halted_r   <= halted_r || stop_req_r;
      out_cause_r    <= stop_req_r ? stop_code_r : cause_r;
      out_pc_r       <= next_r;
      out_cvalid_r   <= cvalid_r;
      out_char_r     <= cchar_r;
      out_consumed_r <= consumed_r;
      out_retired_r  <= retired_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_halted           = out_halted_r;
  assign out_halt_cause       = out_cause_r;
  assign out_next_pc          = out_pc_r;
  assign out_char_out_valid   = out_cvalid_r;
  assign out_char_out         = out_char_r;
  assign out_console_consumed = out_consumed_r;
  assign out_retired_count    = out_retired_r;

  // A stopped core stays stopped until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halted flag cleared");

  // The stop cause is nonzero exactly when the core is stopped.
  a_cause_match: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r == (cause_r != CAUSE_RUN)) else $error("stop cause mismatch");

  // Register x0 never becomes a written entry.
  a_x0_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0]) else $error("x0 written");

  // Registers and memory are never written in the same cycle.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(rf_we && mem_we)) else $error("overlapping writes");

endmodule
